// ===== rtl/core/assert_macros.svh =====
// Assertion helpers used by the top-level RTL file to check its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define GCD_ASSERT_HOLDS(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gcd assertion failed");

// Next-cycle implication, checked out of reset.
`define GCD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gcd assertion failed");

`endif

// ===== rtl/core/gcd_pkg.sv =====
`default_nettype none

package gcd_pkg;

  // Default number of CORDIC steps for sine, cosine and arccosine.
  localparam int ANGLE_ITERATIONS_DEF = 24;

  // Angle constants in micro-degrees.
  localparam logic signed [31:0] TURN_MICRO    = 32'sd360000000;
  localparam logic signed [31:0] HALF_TURN     = 32'sd180000000;
  localparam logic signed [31:0] QUARTER_TURN  = 32'sd90000000;

  // Degrees to Q30 radians: z = 18*mag + round(mag * 66629713 / 90000000).
  localparam logic [26:0] RAD_DIVISOR = 27'd90000000;
  localparam logic [26:0] RAD_REM_MUL = 27'd66629713;
  localparam logic [26:0] RAD_HALF    = 27'd45000000;
  localparam logic [31:0] RAD_RECIP   = 32'((64'd66629713 << 32) / 64'd90000000);

  // Q30 constants.
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [34:0] HALF_PI_Q30 = 35'sd1686629713;
  localparam logic signed [31:0] ONE_Q30     = 32'sd1073741824;

  // Output scaling.
  localparam logic [22:0] EARTH_RADIUS = 23'd6378137;
  localparam logic [24:0] MAX_DISTANCE = 25'd20037509;

  // Depth of the queue between front and back.
  localparam int QDEPTH = 4;

  // One classified item: three angles in Q30 radians and their cosine signs.
  typedef struct packed {
    logic signed [31:0] z1;
    logic signed [31:0] z2;
    logic signed [31:0] zd;
    logic               neg1;
    logic               neg2;
    logic               negd;
  } gcd_item_t;

  // Queue status seen by the top level.
  typedef struct packed {
    logic full;
    logic empty;
  } gcd_qstat_t;

  // atan(2^-i) in Q30, truncated.
  function automatic logic [29:0] atan_q30(input logic [4:0] i);
    logic [29:0] v;
    unique case (i)
      5'd0:  v = 30'h3243F6A8;
      5'd1:  v = 30'h1DAC6705;
      5'd2:  v = 30'h0FADBAFC;
      5'd3:  v = 30'h07F56EA6;
      5'd4:  v = 30'h03FEAB76;
      5'd5:  v = 30'h01FFD55B;
      5'd6:  v = 30'h00FFFAAA;
      5'd7:  v = 30'h007FFF55;
      5'd8:  v = 30'h003FFFEA;
      5'd9:  v = 30'h001FFFFD;
      5'd10: v = 30'h000FFFFF;
      5'd11: v = 30'h0007FFFF;
      5'd12: v = 30'h0003FFFF;
      5'd13: v = 30'h0001FFFF;
      5'd14: v = 30'h0000FFFF;
      5'd15: v = 30'h00007FFF;
      5'd16: v = 30'h00003FFF;
      5'd17: v = 30'h00001FFF;
      5'd18: v = 30'h00000FFF;
      5'd19: v = 30'h000007FF;
      5'd20: v = 30'h000003FF;
      5'd21: v = 30'h000001FF;
      5'd22: v = 30'h000000FF;
      5'd23: v = 30'h0000007F;
      5'd24: v = 30'h0000003F;
      5'd25: v = 30'h0000001F;
      5'd26: v = 30'h0000000F;
      5'd27: v = 30'h00000008;
      5'd28: v = 30'h00000004;
      5'd29: v = 30'h00000002;
      5'd30: v = 30'h00000001;
      5'd31: v = 30'h00000000;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/gcd_front.sv =====
`default_nettype none

module gcd_front (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     take,
  input  wire logic signed [27:0]       lat1,
  input  wire logic signed [28:0]       lon1,
  input  wire logic signed [27:0]       lat2,
  input  wire logic signed [28:0]       lon2,
  output logic                          item_vld,
  output gcd_pkg::gcd_item_t            item
);

  logic              v0_r, v1_r, v2_r, v3_r, v4_r;
  logic signed [31:0] a_r   [3];
  logic [26:0]       mag1_r [3];
  logic              sgn1_r [3];
  logic              neg1_r [3];
  logic [58:0]       m1_r   [3];
  logic [53:0]       p2_r   [3];
  logic [26:0]       mag2_r [3];
  logic              sgn2_r [3];
  logic              neg2_r [3];
  logic [26:0]       e3_r   [3];
  logic [53:0]       re3_r  [3];
  logic [53:0]       p3_r   [3];
  logic [26:0]       mag3_r [3];
  logic              sgn3_r [3];
  logic              neg3_r [3];
  logic signed [31:0] z_nxt [3];
  gcd_pkg::gcd_item_t item_r;

  // Valid bits follow the beat through the five front stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v0_r <= take;
      v1_r <= v0_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  // Capture the latitudes and the longitude difference.
  always_ff @(posedge clk) begin
    a_r[0] <= 32'(lat1);
    a_r[1] <= 32'(lat2);
    a_r[2] <= 32'(lon2) - 32'(lon1);
  end

  for (genvar k = 0; k < 3; k++) begin : g_lane
    logic signed [31:0] r1, r2, r3;
    logic               neg;
    logic signed [55:0] rem;
    logic [26:0]        q;
    logic [31:0]        zmag;

    // Reduce to one turn, then to a half turn, then fold into a quarter turn.
    always_comb begin
      if (a_r[k] >= gcd_pkg::TURN_MICRO) begin
        r1 = a_r[k] - gcd_pkg::TURN_MICRO;
      end else if (a_r[k] <= -gcd_pkg::TURN_MICRO) begin
        r1 = a_r[k] + gcd_pkg::TURN_MICRO;
      end else begin
        r1 = a_r[k];
      end
      if (r1 > gcd_pkg::HALF_TURN) begin
        r2 = r1 - gcd_pkg::TURN_MICRO;
      end else if (r1 <= -gcd_pkg::HALF_TURN) begin
        r2 = r1 + gcd_pkg::TURN_MICRO;
      end else begin
        r2 = r1;
      end
      neg = 1'b0;
      if (r2 > gcd_pkg::QUARTER_TURN) begin
        r3  = gcd_pkg::HALF_TURN - r2;
        neg = 1'b1;
      end else if (r2 < -gcd_pkg::QUARTER_TURN) begin
        r3  = -gcd_pkg::HALF_TURN - r2;
        neg = 1'b1;
      end else begin
        r3 = r2;
      end
    end

    always_ff @(posedge clk) begin
      mag1_r[k] <= r3[31] ? 27'(-r3) : 27'(r3);
      sgn1_r[k] <= r3[31];
      neg1_r[k] <= neg;
    end

    // Reciprocal estimate of the quotient and the exact dividend.
    always_ff @(posedge clk) begin
      m1_r[k]   <= 59'(mag1_r[k]) * 59'(gcd_pkg::RAD_RECIP);
      p2_r[k]   <= 54'(mag1_r[k]) * 54'(gcd_pkg::RAD_REM_MUL) + 54'(gcd_pkg::RAD_HALF);
      mag2_r[k] <= mag1_r[k];
      sgn2_r[k] <= sgn1_r[k];
      neg2_r[k] <= neg1_r[k];
    end

    // Multiply the estimate back for the remainder check.
    always_ff @(posedge clk) begin
      e3_r[k]   <= 27'((m1_r[k] + 59'd2147483648) >> 32);
      re3_r[k]  <= 54'(27'((m1_r[k] + 59'd2147483648) >> 32)) * 54'(gcd_pkg::RAD_DIVISOR);
      p3_r[k]   <= p2_r[k];
      mag3_r[k] <= mag2_r[k];
      sgn3_r[k] <= sgn2_r[k];
      neg3_r[k] <= neg2_r[k];
    end

    // Correct the estimate by one and build the signed Q30 angle.
    always_comb begin
      rem = $signed({2'b00, p3_r[k]}) - $signed({2'b00, re3_r[k]});
      if (rem[55]) begin
        q = e3_r[k] - 27'd1;
      end else if (rem >= $signed(56'(gcd_pkg::RAD_DIVISOR))) begin
        q = e3_r[k] + 27'd1;
      end else begin
        q = e3_r[k];
      end
      zmag     = 32'(mag3_r[k]) * 32'd18 + 32'(q);
      z_nxt[k] = sgn3_r[k] ? -$signed(zmag) : $signed(zmag);
    end
  end

  always_ff @(posedge clk) begin
    item_r.z1   <= z_nxt[0];
    item_r.z2   <= z_nxt[1];
    item_r.zd   <= z_nxt[2];
    item_r.neg1 <= neg3_r[0];
    item_r.neg2 <= neg3_r[1];
    item_r.negd <= neg3_r[2];
  end

  assign item_vld = v4_r;
  assign item     = item_r;

endmodule

`default_nettype wire

// ===== rtl/core/gcd_queue.sv =====
`default_nettype none

module gcd_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  gcd_pkg::gcd_item_t      push_item,
  output logic                    pop_vld,
  output gcd_pkg::gcd_item_t      pop_item,
  output gcd_pkg::gcd_qstat_t     stat
);

  localparam int AW = $clog2(gcd_pkg::QDEPTH);

  gcd_pkg::gcd_item_t mem [gcd_pkg::QDEPTH];
  logic [AW-1:0]      wr_ptr_r, rd_ptr_r;
  logic [AW:0]        cnt_r;
  logic               pop;
  logic               pop_vld_r;
  gcd_pkg::gcd_item_t rd_r;

  // The back side never stalls, so any stored beat is taken at once.
  assign pop = (cnt_r != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r  <= '0;
      rd_ptr_r  <= '0;
      cnt_r     <= '0;
      pop_vld_r <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r     <= cnt_r + (AW+1)'(push) - (AW+1)'(pop);
      pop_vld_r <= pop;
    end
  end

  // Storage with a registered read port.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_item;
    end
    if (pop) begin
      rd_r <= mem[rd_ptr_r];
    end
  end

  assign pop_vld    = pop_vld_r;
  assign pop_item   = rd_r;
  assign stat.full  = (cnt_r == (AW+1)'(gcd_pkg::QDEPTH));
  assign stat.empty = (cnt_r == '0);

endmodule

`default_nettype wire

// ===== rtl/core/gcd_sincos.sv =====
`default_nettype none

module gcd_sincos #(
  parameter int ANGLE_ITERATIONS = gcd_pkg::ANGLE_ITERATIONS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_vld,
  input  wire logic signed [31:0] z_in,
  input  wire logic              neg_in,
  output logic                   out_vld,
  output logic signed [31:0]     sin_out,
  output logic signed [31:0]     cos_out
);

  // The arctangent table has 32 entries, so longer chains stop there.
  localparam int N = (ANGLE_ITERATIONS > 32) ? 32 : ANGLE_ITERATIONS;

  logic               vld_r [N+1];
  logic signed [33:0] x_r   [N+1];
  logic signed [33:0] y_r   [N+1];
  logic signed [33:0] z_r   [N+1];
  logic               neg_r [N+1];
  logic               out_vld_r;
  logic signed [31:0] sin_r, cos_r;

  // Load the rotation with the gain-compensated unit vector.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    x_r[0]   <= gcd_pkg::CORDIC_GAIN;
    y_r[0]   <= '0;
    z_r[0]   <= 34'(z_in);
    neg_r[0] <= neg_in;
  end

  // One rotation step per stage, driven by the sign of the residual angle.
  for (genvar i = 0; i < N; i++) begin : g_step
    logic signed [33:0] at;
    assign at = $signed({4'b0000, gcd_pkg::atan_q30(5'(i))});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else begin
        vld_r[i+1] <= vld_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (!z_r[i][33]) begin
        x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] - at;
      end else begin
        x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] + at;
      end
      neg_r[i+1] <= neg_r[i];
    end
  end

  // Restore the cosine sign of the folded angle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= vld_r[N];
    end
  end

  always_ff @(posedge clk) begin
    sin_r <= 32'(y_r[N]);
    cos_r <= neg_r[N] ? 32'(-x_r[N]) : 32'(x_r[N]);
  end

  assign out_vld = out_vld_r;
  assign sin_out = sin_r;
  assign cos_out = cos_r;

endmodule

`default_nettype wire

// ===== rtl/core/gcd_back.sv =====
`default_nettype none

module gcd_back #(
  parameter int ANGLE_ITERATIONS = gcd_pkg::ANGLE_ITERATIONS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_vld,
  input  gcd_pkg::gcd_item_t     in_item,
  output logic                   out_vld,
  output logic [24:0]            out_dist
);

  // The arctangent table has 32 entries, so longer chains stop there.
  localparam int N  = (ANGLE_ITERATIONS > 32) ? 32 : ANGLE_ITERATIONS;
  localparam int SQ = 31;

  logic               sc_vld [3];
  logic signed [31:0] s1, c1, s2, c2, sd, cd;
  logic               vb1_r, vb2_r, vb3_r, vb4_r;
  logic signed [63:0] p1_r, p2_r, p1b_r, p3_r;
  logic signed [31:0] cd_r;
  logic signed [34:0] sum;
  logic signed [31:0] v_r, v4_r;
  logic [61:0]        vsq_r;
  logic               sq_vld_r [SQ+1];
  logic [61:0]        sq_rem_r [SQ+1];
  logic [61:0]        sq_res_r [SQ+1];
  logic signed [31:0] sq_v_r   [SQ+1];
  logic               vc_vld_r [N+1];
  logic signed [34:0] vx_r     [N+1];
  logic signed [34:0] vy_r     [N+1];
  logic signed [34:0] vz_r     [N+1];
  logic signed [34:0] root;
  logic [31:0]        ang;
  logic               fa_vld_r, fb_vld_r;
  logic [54:0]        prod_r;
  logic [25:0]        m;
  logic [24:0]        dist_r;

  // Sine and cosine of both latitudes and of the longitude difference.
  gcd_sincos #(.ANGLE_ITERATIONS(N)) u_sc1 (
    .clk(clk), .rst_n(rst_n), .in_vld(in_vld), .z_in(in_item.z1), .neg_in(in_item.neg1),
    .out_vld(sc_vld[0]), .sin_out(s1), .cos_out(c1)
  );
  gcd_sincos #(.ANGLE_ITERATIONS(N)) u_sc2 (
    .clk(clk), .rst_n(rst_n), .in_vld(in_vld), .z_in(in_item.z2), .neg_in(in_item.neg2),
    .out_vld(sc_vld[1]), .sin_out(s2), .cos_out(c2)
  );
  gcd_sincos #(.ANGLE_ITERATIONS(N)) u_scd (
    .clk(clk), .rst_n(rst_n), .in_vld(in_vld), .z_in(in_item.zd), .neg_in(in_item.negd),
    .out_vld(sc_vld[2]), .sin_out(sd), .cos_out(cd)
  );

  // Control for the cosine combine and square stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb1_r <= 1'b0;
      vb2_r <= 1'b0;
      vb3_r <= 1'b0;
      vb4_r <= 1'b0;
    end else begin
      vb1_r <= sc_vld[0] & sc_vld[1] & sc_vld[2];
      vb2_r <= vb1_r;
      vb3_r <= vb2_r;
      vb4_r <= vb3_r;
    end
  end

  // Central cosine: s1*s2 + (c1*c2)*cd, each product rescaled to Q30.
  always_ff @(posedge clk) begin
    p1_r  <= 64'(s1) * 64'(s2);
    p2_r  <= 64'(c1) * 64'(c2);
    cd_r  <= cd;
    p1b_r <= p1_r;
    p3_r  <= 64'(32'(p2_r >>> 30)) * 64'(cd_r);
  end

  // Sum and clamp to the range of a cosine.
  always_comb begin
    sum = 35'(p1b_r >>> 30) + 35'(p3_r >>> 30);
  end

  always_ff @(posedge clk) begin
    if (sum > 35'(gcd_pkg::ONE_Q30)) begin
      v_r <= gcd_pkg::ONE_Q30;
    end else if (sum < -35'(gcd_pkg::ONE_Q30)) begin
      v_r <= -gcd_pkg::ONE_Q30;
    end else begin
      v_r <= 32'(sum);
    end
    vsq_r <= 62'(64'(v_r) * 64'(v_r));
    v4_r  <= v_r;
  end

  // Integer square root of 1 - v^2, one result bit per stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_vld_r[0] <= 1'b0;
    end else begin
      sq_vld_r[0] <= vb4_r;
    end
  end

  always_ff @(posedge clk) begin
    sq_rem_r[0] <= (62'd1 << 60) - vsq_r;
    sq_res_r[0] <= '0;
    sq_v_r[0]   <= v4_r;
  end

  for (genvar i = 0; i < SQ; i++) begin : g_sqrt
    localparam logic [61:0] BIT = 62'd1 << (60 - 2 * i);
    logic [61:0] trial;
    assign trial = sq_res_r[i] + BIT;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_vld_r[i+1] <= 1'b0;
      end else begin
        sq_vld_r[i+1] <= sq_vld_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (sq_rem_r[i] >= trial) begin
        sq_rem_r[i+1] <= sq_rem_r[i] - trial;
        sq_res_r[i+1] <= (sq_res_r[i] >> 1) + BIT;
      end else begin
        sq_rem_r[i+1] <= sq_rem_r[i];
        sq_res_r[i+1] <= sq_res_r[i] >> 1;
      end
      sq_v_r[i+1] <= sq_v_r[i];
    end
  end

  // Vectoring start point; a negative cosine starts a quarter turn on.
  assign root = $signed({4'b0000, sq_res_r[SQ][30:0]});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_vld_r[0] <= 1'b0;
    end else begin
      vc_vld_r[0] <= sq_vld_r[SQ];
    end
  end

  always_ff @(posedge clk) begin
    if (sq_v_r[SQ][31]) begin
      vx_r[0] <= root;
      vy_r[0] <= -35'(sq_v_r[SQ]);
      vz_r[0] <= gcd_pkg::HALF_PI_Q30;
    end else begin
      vx_r[0] <= 35'(sq_v_r[SQ]);
      vy_r[0] <= root;
      vz_r[0] <= '0;
    end
  end

  // Vectoring steps drive y to zero and collect the angle.
  for (genvar i = 0; i < N; i++) begin : g_vec
    logic signed [34:0] at;
    assign at = $signed({5'b00000, gcd_pkg::atan_q30(5'(i))});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vc_vld_r[i+1] <= 1'b0;
      end else begin
        vc_vld_r[i+1] <= vc_vld_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (!vy_r[i][34]) begin
        vx_r[i+1] <= vx_r[i] + (vy_r[i] >>> i);
        vy_r[i+1] <= vy_r[i] - (vx_r[i] >>> i);
        vz_r[i+1] <= vz_r[i] + at;
      end else begin
        vx_r[i+1] <= vx_r[i] - (vy_r[i] >>> i);
        vy_r[i+1] <= vy_r[i] + (vx_r[i] >>> i);
        vz_r[i+1] <= vz_r[i] - at;
      end
    end
  end

  // Scale the angle by the radius, round to meters and saturate.
  assign ang = vz_r[N][34] ? 32'd0 : 32'(vz_r[N]);
  assign m   = 26'((prod_r + (55'd1 << 29)) >> 30);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fa_vld_r <= 1'b0;
      fb_vld_r <= 1'b0;
    end else begin
      fa_vld_r <= vc_vld_r[N];
      fb_vld_r <= fa_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= 55'(ang) * 55'(gcd_pkg::EARTH_RADIUS);
    dist_r <= (m > 26'(gcd_pkg::MAX_DISTANCE)) ? gcd_pkg::MAX_DISTANCE : 25'(m);
  end

  assign out_vld  = fb_vld_r;
  assign out_dist = dist_r;

endmodule

`default_nettype wire

// ===== rtl/core/great_circle_distance.sv =====
`default_nettype none
`include "assert_macros.svh"

// Great-circle distance between two positions, by the spherical law of cosines.
// Input: a beat is taken at a rising edge where start is high and busy is low.
// It carries two latitude/longitude pairs in signed micro-degrees.
// Output: out_valid is high for exactly one cycle with out_distance_meters,
// the distance in whole meters on a 6378137 m sphere, saturated at 20037509.
// Throughput: one beat per cycle, sustained; every stage is pipelined.
// The result path runs through the sine/cosine CORDIC pipeline, the
// 31-stage square root and the arccosine CORDIC pipeline.
// The front stage reduces and converts angles; a four-entry queue sits
// between it and the back end, which drains it every cycle, so busy stays low.
// The receiver cannot stall; results leave in acceptance order.
// Reset clears every valid bit and the queue; beats in flight are dropped.
module great_circle_distance #(
  parameter int ANGLE_ITERATIONS = gcd_pkg::ANGLE_ITERATIONS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [27:0] in_first_latitude,
  input  wire logic signed [28:0] in_first_longitude,
  input  wire logic signed [27:0] in_second_latitude,
  input  wire logic signed [28:0] in_second_longitude,
  output logic                    out_valid,
  output logic [24:0]             out_distance_meters
);

  logic                 take;
  logic                 front_vld;
  gcd_pkg::gcd_item_t   front_item;
  logic                 q_vld;
  gcd_pkg::gcd_item_t   q_item;
  gcd_pkg::gcd_qstat_t  q_stat;

  assign take = start & ~busy;
  assign busy = q_stat.full;

  gcd_front u_front (
    .clk(clk), .rst_n(rst_n), .take(take),
    .lat1(in_first_latitude), .lon1(in_first_longitude),
    .lat2(in_second_latitude), .lon2(in_second_longitude),
    .item_vld(front_vld), .item(front_item)
  );

  gcd_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(front_vld), .push_item(front_item),
    .pop_vld(q_vld), .pop_item(q_item), .stat(q_stat)
  );

  gcd_back #(.ANGLE_ITERATIONS(ANGLE_ITERATIONS)) u_back (
    .clk(clk), .rst_n(rst_n), .in_vld(q_vld), .in_item(q_item),
    .out_vld(out_valid), .out_dist(out_distance_meters)
  );

  // The queue never overflows, never backs up, and results stay in range.
  `GCD_ASSERT_HOLDS(a_no_overflow, clk, rst_n, front_vld, !q_stat.full)
  `GCD_ASSERT_HOLDS(a_never_busy, clk, rst_n, 1'b1, !busy)
  `GCD_ASSERT_NEXT(a_queue_drains, clk, rst_n, !q_stat.empty && !front_vld, q_stat.empty)
  `GCD_ASSERT_HOLDS(a_dist_range, clk, rst_n, out_valid,
                    out_distance_meters <= gcd_pkg::MAX_DISTANCE)

endmodule

`default_nettype wire
